// File: hw/rtl/blcs_pkg.sv
// ----------------------------------------------------------------------------
// blcs_pkg - shared types and constants for the bit-plane life cell step unit
// Sequencer states, register indexes, neighborhood tap tables and the
// per-cell birth/survival rule.
// ----------------------------------------------------------------------------
package blcs_pkg;

    localparam int unsigned PIX_W       = 24;
    localparam int unsigned RULE_W      = 18;
    localparam int unsigned CNT_W       = 7;
    localparam int unsigned NBR_W       = 4;    // neighbor count 0..8
    localparam int unsigned TAP_W       = 4;    // tap index 0..8
    localparam int unsigned SURVIVE_SHIFT = 9;

    localparam logic [TAP_W-1:0] CENTER_TAP = 4'd4;
    localparam logic [TAP_W-1:0] LAST_TAP   = 4'd8;

    localparam logic [RULE_W-1:0] RULE_RESET = 18'h01808;
    localparam logic [CNT_W-1:0]  COUNT_RESET = 7'd64;

    typedef enum logic [1:0] {
        CFG_RULE = 2'd0,
        CFG_ROWS = 2'd1,
        CFG_COLS = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_WRITE,
        ST_READ,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // Neighborhood position of a tap: 0 = previous, 1 = same, 2 = next.
    typedef enum logic [1:0] {
        POS_PREV = 2'd0,
        POS_SAME = 2'd1,
        POS_NEXT = 2'd2
    } t_pos;

    function automatic t_pos tap_row(input logic [TAP_W-1:0] tap);
        t_pos pos;
        unique case (tap)
            4'd0, 4'd1, 4'd2: pos = POS_PREV;
            4'd3, 4'd4, 4'd5: pos = POS_SAME;
            default:          pos = POS_NEXT;
        endcase
        return pos;
    endfunction

    function automatic t_pos tap_col(input logic [TAP_W-1:0] tap);
        t_pos pos;
        unique case (tap)
            4'd0, 4'd3, 4'd6: pos = POS_PREV;
            4'd1, 4'd4, 4'd7: pos = POS_SAME;
            default:          pos = POS_NEXT;
        endcase
        return pos;
    endfunction

    // Birth looks at rule bit n, survival at rule bit n + 9.
    function automatic logic cell_next(input logic [RULE_W-1:0] rule,
                                       input logic [NBR_W-1:0]  nbrs,
                                       input logic              alive);
        logic [4:0] sel;
        sel = alive ? (5'(nbrs) + 5'(SURVIVE_SHIFT)) : 5'(nbrs);
        return rule[sel];
    endfunction

endpackage

// File: hw/rtl/blcs_ram.sv
// ----------------------------------------------------------------------------
// blcs_ram - generic single-port RAM
// One access per cycle; read data registered, and a write cycle returns the old contents.
// ----------------------------------------------------------------------------
module blcs_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/bitplane_life_cell_step_unit.sv
// ----------------------------------------------------------------------------
// bitplane_life_cell_step_unit - life-like automaton step on RGB bit planes
// Stores a toroidal grid of 24-bit pixels and returns, on request, the
// next-generation pixel at one coordinate, each bit plane run as its own
// life-like cellular automaton under a birth/survival rule mask.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+------------------------------
//  command   | in        | start, busy            | i_mode i_row i_col i_*_in
//  result    | out       | o_done (1-cycle strobe)| o_red_out o_green_out o_blue_out
//  config    | in        | i_cfg_we               | i_cfg_idx i_cfg_data
//
//  A write command (mode 0) runs through capture, clamp, RAM write.
//  A compute command (mode 1) runs from transfer to strobe through
//  capture, clamp, nine reads of the single-port pixel RAM (one per cycle),
//  a drain state for the last registered read, a done state to apply the
//  rule. busy is high for the whole item; a new command transfers in the cycle
//  the result strobe is shown. The receiver cannot stall the result.
//  Reset (synchronous, active low) clears the sequencer and the config
//  registers; the pixel RAM is not cleared and reads of unwritten entries
//  are undefined.
//
module bitplane_life_cell_step_unit #(
    parameter int unsigned MAX_ROWS = 64,
    parameter int unsigned MAX_COLS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [5:0]  i_row,
    input  logic [5:0]  i_col,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,

    output logic        o_done,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,

    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [17:0] i_cfg_data
);

    localparam int unsigned DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int unsigned AW     = $clog2(DEPTH);
    localparam int unsigned RW_RAW = $clog2(MAX_ROWS + 1);
    localparam int unsigned CW_RAW = $clog2(MAX_COLS + 1);
    // Row/column math width: holds the count register and the max count.
    localparam int unsigned RW     = (RW_RAW > 7) ? RW_RAW : 7;
    localparam int unsigned CW     = (CW_RAW > 7) ? CW_RAW : 7;
    localparam int unsigned PW     = blcs_pkg::PIX_W;
    localparam int unsigned NW     = blcs_pkg::NBR_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [blcs_pkg::RULE_W-1:0] r_rule;
    logic [blcs_pkg::CNT_W-1:0]  r_rows_cfg;
    logic [blcs_pkg::CNT_W-1:0]  r_cols_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule     <= blcs_pkg::RULE_RESET;
            r_rows_cfg <= blcs_pkg::COUNT_RESET;
            r_cols_cfg <= blcs_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                blcs_pkg::CFG_RULE: r_rule     <= i_cfg_data;
                blcs_pkg::CFG_ROWS: r_rows_cfg <= i_cfg_data[blcs_pkg::CNT_W-1:0];
                blcs_pkg::CFG_COLS: r_cols_cfg <= i_cfg_data[blcs_pkg::CNT_W-1:0];
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    blcs_pkg::t_state r_state, n_state;
    logic [blcs_pkg::TAP_W-1:0] r_idx, n_idx;

    logic w_accept;
    assign busy     = (r_state != blcs_pkg::ST_IDLE);
    assign w_accept = start && !busy;

    // Captured command
    logic          r_mode;
    logic [5:0]    r_row_in;
    logic [5:0]    r_col_in;
    logic [PW-1:0] r_pix;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode   <= i_mode;
            r_row_in <= i_row;
            r_col_in <= i_col;
            r_pix    <= {i_red_in, i_green_in, i_blue_in};
        end
    end

    // Effective counts: zero acts as one, above the maximum acts as the maximum.
    logic [RW-1:0] w_nr, w_r;
    logic [CW-1:0] w_nc, w_c;
    always_comb begin
        w_nr = RW'(r_rows_cfg);
        if (w_nr == '0) begin
            w_nr = RW'(1);
        end else if (w_nr > RW'(MAX_ROWS)) begin
            w_nr = RW'(MAX_ROWS);
        end
        w_nc = CW'(r_cols_cfg);
        if (w_nc == '0) begin
            w_nc = CW'(1);
        end else if (w_nc > CW'(MAX_COLS)) begin
            w_nc = CW'(MAX_COLS);
        end
        // Clamp a coordinate at or beyond the count to the last row/column.
        w_r = (RW'(r_row_in) >= w_nr) ? w_nr - RW'(1) : RW'(r_row_in);
        w_c = (CW'(r_col_in) >= w_nc) ? w_nc - CW'(1) : CW'(r_col_in);
    end

    // Clamped coordinate and counts, held for the rest of the item
    logic [RW-1:0] r_nr, r_r;
    logic [CW-1:0] r_nc, r_c;
    always_ff @(posedge i_clk) begin
        if (r_state == blcs_pkg::ST_CLAMP) begin
            r_nr <= w_nr;
            r_nc <= w_nc;
            r_r  <= w_r;
            r_c  <= w_c;
        end
    end

    // Toroidal neighbors of the held coordinate
    logic [RW-1:0] w_r_prev, w_r_next, w_r_sel;
    logic [CW-1:0] w_c_prev, w_c_next, w_c_sel;
    logic [blcs_pkg::TAP_W-1:0] w_tap;
    always_comb begin
        w_r_prev = (r_r == '0) ? r_nr - RW'(1) : r_r - RW'(1);
        w_r_next = (r_r + RW'(1) >= r_nr) ? '0 : r_r + RW'(1);
        w_c_prev = (r_c == '0) ? r_nc - CW'(1) : r_c - CW'(1);
        w_c_next = (r_c + CW'(1) >= r_nc) ? '0 : r_c + CW'(1);

        w_tap = (r_state == blcs_pkg::ST_READ) ? r_idx : blcs_pkg::CENTER_TAP;

        unique case (blcs_pkg::tap_row(w_tap))
            blcs_pkg::POS_PREV: w_r_sel = w_r_prev;
            blcs_pkg::POS_SAME: w_r_sel = r_r;
            default:            w_r_sel = w_r_next;
        endcase
        unique case (blcs_pkg::tap_col(w_tap))
            blcs_pkg::POS_PREV: w_c_sel = w_c_prev;
            blcs_pkg::POS_SAME: w_c_sel = r_c;
            default:            w_c_sel = w_c_next;
        endcase
    end

    // ------------------------------------------------------------------
    // Pixel memory
    // ------------------------------------------------------------------
    logic [AW-1:0] w_addr;
    logic          w_ram_we;
    logic [PW-1:0] w_rdata;

    assign w_addr   = AW'(w_r_sel) * AW'(MAX_COLS) + AW'(w_c_sel);
    assign w_ram_we = (r_state == blcs_pkg::ST_WRITE);

    blcs_ram #(
        .WIDTH (PW),
        .DEPTH (DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_addr),
        .i_wdata (r_pix),
        .o_rdata (w_rdata)
    );

    // ------------------------------------------------------------------
    // State register and next-state logic
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= blcs_pkg::ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            blcs_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = blcs_pkg::ST_CLAMP;
                end
            end
            blcs_pkg::ST_CLAMP: begin
                n_idx   = '0;
                n_state = r_mode ? blcs_pkg::ST_READ : blcs_pkg::ST_WRITE;
            end
            blcs_pkg::ST_WRITE: begin
                n_state = blcs_pkg::ST_IDLE;
            end
            blcs_pkg::ST_READ: begin
                // advance one tap per cycle through the 3x3 window
                n_idx = r_idx + blcs_pkg::TAP_W'(1);
                if (r_idx == blcs_pkg::LAST_TAP) begin
                    n_state = blcs_pkg::ST_DRAIN;
                end
            end
            blcs_pkg::ST_DRAIN: begin
                n_state = blcs_pkg::ST_DONE;
            end
            blcs_pkg::ST_DONE: begin
                n_state = blcs_pkg::ST_IDLE;
            end
            default: begin
                n_state = blcs_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Neighbor count accumulator: 24 lane counters, one tap per cycle
    // ------------------------------------------------------------------
    logic                       r_rd_vld;
    logic [blcs_pkg::TAP_W-1:0] r_rd_idx;
    logic [PW-1:0]              r_self;
    logic [NW-1:0]              r_nbr [PW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == blcs_pkg::ST_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx;
        if (r_state == blcs_pkg::ST_CLAMP) begin
            for (int b = 0; b < PW; b++) begin
                r_nbr[b] <= '0;
            end
        end else if (r_rd_vld) begin
            if (r_rd_idx == blcs_pkg::CENTER_TAP) begin
                r_self <= w_rdata;
            end else begin
                for (int b = 0; b < PW; b++) begin
                    r_nbr[b] <= r_nbr[b] + NW'(w_rdata[b]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Rule application and result register
    // ------------------------------------------------------------------
    logic [PW-1:0] w_next;
    always_comb begin
        for (int b = 0; b < PW; b++) begin
            w_next[b] = blcs_pkg::cell_next(r_rule, r_nbr[b], r_self[b]);
        end
    end

    logic          r_done;
    logic [PW-1:0] r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == blcs_pkg::ST_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == blcs_pkg::ST_DONE) begin
            r_out <= w_next;
        end
    end

    assign o_done      = r_done;
    assign o_red_out   = r_out[23:16];
    assign o_green_out = r_out[15:8];
    assign o_blue_out  = r_out[7:0];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_after_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == blcs_pkg::ST_DONE))
        else $error("result strobe without a finished compute");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("busy not raised after a command transfer");

    a_no_result_for_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == blcs_pkg::ST_WRITE) |=> !o_done ##1 !o_done)
        else $error("write command produced a result");

    a_tap_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == blcs_pkg::ST_READ) |-> (r_idx <= blcs_pkg::LAST_TAP))
        else $error("tap index ran past the 3x3 window");

endmodule
